// ===== rtl/core/bankers_safe_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Banker's allocator assertion macros
// Shared property shapes for the checks in the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFE_ALLOCATOR_MACROS_SVH
`define BANKERS_SAFE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Banker's allocator package
// Op and status codes, fixed field widths and lane interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

   localparam int LANE_FIELDS = 4;  // resource fields on the ports
   localparam int AMT_W       = 8;
   localparam int TOT_W       = 8;
   localparam int CUST_IN_W   = 3;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 2;

   localparam logic [OP_W-1:0] OP_CLAIM   = 2'd0;
   localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] STS_OVER_NEED    = 3'd1;
   localparam logic [STATUS_W-1:0] STS_OVER_AVAIL   = 3'd2;
   localparam logic [STATUS_W-1:0] STS_UNSAFE       = 3'd3;
   localparam logic [STATUS_W-1:0] STS_OVER_RELEASE = 3'd4;
   localparam logic [STATUS_W-1:0] STS_CLAIM_LOW    = 3'd5;

   // Commands from the sequencer to every resource lane.
   typedef struct packed {
      logic load;      // latch tentative allocation and starting work value
      logic scan;      // safety scan running, overlay tentative allocation
      logic take;      // scanned customer finishes: work += its allocation
      logic claim_we;  // write new claim for the item's customer
      logic rel_we;    // apply a release
      logic commit;    // scan passed: grant the request
   } lane_ctrl_type;

   // Per-lane compare results toward the merge stage.
   typedef struct packed {
      logic claim_low;
      logic over_need;
      logic over_avail;
      logic over_rel;
      logic fits;
   } lane_flag_type;

endpackage

`default_nettype wire

// ===== rtl/core/bsa_lane.sv =====
// ----------------------------------------------------------------------------
// Banker's allocator resource lane
// Claim and allocation store of one resource, its usage sum, work counter
// and the per-resource compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsa_lane
   import bsa_pkg::*;
#(
   parameter int CUSTOMERS  = 8,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lane_ctrl_type                ctrl,
   input  wire logic [TOT_W-1:0]             total,
   input  wire logic [COUNT_BITS-1:0]        amount,
   input  wire logic [$clog2(CUSTOMERS)-1:0] cust_idx,
   input  wire logic [$clog2(CUSTOMERS)-1:0] rd_addr,
   output lane_flag_type                     flags,
   output logic [TOT_W-1:0]                  avail
);

   localparam int CUST_W = $clog2(CUSTOMERS);
   localparam int USED_W = COUNT_BITS + CUST_W;
   localparam int SUM_W  = (USED_W > TOT_W) ? USED_W : TOT_W;
   localparam int WORK_W = SUM_W + 1;
   localparam int CMP_W  = (COUNT_BITS > TOT_W) ? COUNT_BITS : TOT_W;

   logic [COUNT_BITS-1:0] claim_ff [CUSTOMERS];
   logic [COUNT_BITS-1:0] alloc_ff [CUSTOMERS];
   logic [COUNT_BITS-1:0] tent_ff, tent_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [WORK_W-1:0]     work_ff, work_in;

   logic [COUNT_BITS-1:0] rd_claim, rd_alloc, alloc_eff, need;
   logic [SUM_W-1:0]      used_ext, tot_ext;

   assign rd_claim = claim_ff[rd_addr];
   assign rd_alloc = alloc_ff[rd_addr];

   // the requesting customer is seen with the request already added
   assign alloc_eff = (ctrl.scan && (rd_addr == cust_idx)) ? tent_ff : rd_alloc;
   assign need      = (rd_claim > alloc_eff) ? (rd_claim - alloc_eff) : '0;

   assign used_ext = SUM_W'(used_ff);
   assign tot_ext  = SUM_W'(total);
   assign avail    = (tot_ext > used_ext) ? TOT_W'(tot_ext - used_ext) : '0;

   always_comb begin
      flags.claim_low  = (amount < rd_alloc);
      flags.over_rel   = (amount > rd_alloc);
      flags.over_need  = (amount > need);
      flags.over_avail = (CMP_W'(amount) > CMP_W'(avail));
      flags.fits       = (WORK_W'(need) <= work_ff);
   end

   always_comb begin
      tent_in = tent_ff;
      work_in = work_ff;
      used_in = used_ff;
      if (ctrl.load) begin
         tent_in = rd_alloc + amount;
         work_in = WORK_W'(avail) - WORK_W'(amount);
      end
      if (ctrl.take) begin
         work_in = work_ff + WORK_W'(alloc_eff);
      end
      if (ctrl.rel_we) begin
         used_in = used_ff - USED_W'(amount);
      end
      if (ctrl.commit) begin
         used_in = used_ff + USED_W'(amount);
      end
   end

   always_ff @(posedge clock) begin
      tent_ff <= tent_in;
      work_ff <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int i = 0; i < CUSTOMERS; i++) begin
            claim_ff[i] <= '0;
            alloc_ff[i] <= '0;
         end
      end else begin
         used_ff <= used_in;
         if (ctrl.claim_we) begin
            claim_ff[cust_idx] <= amount;
         end
         if (ctrl.rel_we) begin
            alloc_ff[cust_idx] <= rd_alloc - amount;
         end else if (ctrl.commit) begin
            alloc_ff[cust_idx] <= tent_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bsa_merge.sv =====
// ----------------------------------------------------------------------------
// Banker's allocator merge stage
// Combines lane compares into the item's status and the scan fit decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsa_merge
   import bsa_pkg::*;
#(
   parameter int RESOURCES = 4
) (
   input  wire lane_flag_type       flags [RESOURCES],
   input  wire logic [OP_W-1:0]     op,
   input  wire logic                cust_ok,
   output logic [STATUS_W-1:0]      status,
   output logic                     req_ok,
   output logic                     fits_all
);

   logic any_claim_low, any_over_need, any_over_avail, any_over_rel;

   always_comb begin
      any_claim_low  = 1'b0;
      any_over_need  = 1'b0;
      any_over_avail = 1'b0;
      any_over_rel   = 1'b0;
      fits_all       = 1'b1;
      for (int r = 0; r < RESOURCES; r++) begin
         any_claim_low  = any_claim_low  | flags[r].claim_low;
         any_over_need  = any_over_need  | flags[r].over_need;
         any_over_avail = any_over_avail | flags[r].over_avail;
         any_over_rel   = any_over_rel   | flags[r].over_rel;
         fits_all       = fits_all       & flags[r].fits;
      end
   end

   // need is checked before availability
   always_comb begin
      status = STS_OK;
      req_ok = 1'b0;
      if (cust_ok) begin
         case (op)
            OP_CLAIM: begin
               if (any_claim_low) status = STS_CLAIM_LOW;
            end
            OP_REQUEST: begin
               if (any_over_need)       status = STS_OVER_NEED;
               else if (any_over_avail) status = STS_OVER_AVAIL;
               else                     req_ok = 1'b1;
            end
            OP_RELEASE: begin
               if (any_over_rel) status = STS_OVER_RELEASE;
            end
            default: begin
               status = STS_OK;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bankers_safe_allocator.sv =====
// ----------------------------------------------------------------------------
// Banker's safe allocator
// Deadlock-avoidance resource allocator: claim, request and release ops with
// a safety scan over all customers before any request is granted.
// ----------------------------------------------------------------------------
// One item is handled at a time. Claims, releases, ignored ops and rejected
// requests pass through a check state and then a finish state before their
// result is presented. A request that passes the need and availability
// checks runs the safety scan, which examines one customer per cycle with all
// resource lanes compared side by side; it ends once every customer has
// finished or CUSTOMERS steps in a row make no progress. Such a request goes
// through check, the scan steps, a closing scan step, then finish. A new item
// is taken as soon as the block is back in idle, even while the last result
// still waits in the output register. Available counts are kept as configured
// total minus a running per-resource sum of allocations, saturating at zero if
// a total is lowered below what is allocated. Totals are to be written through
// the csr port only while the block is idle; the block itself does not enforce
// this. Stores come out of reset all zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bankers_safe_allocator_macros.svh"

module bankers_safe_allocator
   import bsa_pkg::*;
#(
   parameter int CUSTOMERS  = 8,
   parameter int RESOURCES  = 4,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [OP_W-1:0]       req_op,
   input  wire logic [CUST_IN_W-1:0]  req_customer,
   input  wire logic [AMT_W-1:0]      req_amount_0,
   input  wire logic [AMT_W-1:0]      req_amount_1,
   input  wire logic [AMT_W-1:0]      req_amount_2,
   input  wire logic [AMT_W-1:0]      req_amount_3,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [TOT_W-1:0]           rsp_avail_0,
   output logic [TOT_W-1:0]           rsp_avail_1,
   output logic [TOT_W-1:0]           rsp_avail_2,
   output logic [TOT_W-1:0]           rsp_avail_3,
   // configuration writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [TOT_W-1:0]      csr_wdata
);

   localparam int CUST_W  = $clog2(CUSTOMERS);
   localparam int CNT_W   = $clog2(CUSTOMERS + 1);
   localparam int CNT_MAX = (1 << COUNT_BITS) - 1;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   // ---- configuration: system totals per resource
   logic [TOT_W-1:0] total_ff [LANE_FIELDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_FIELDS; i++) total_ff[i] <= '0;
      end else if (csr_we) begin
         total_ff[csr_index] <= csr_wdata;
      end
   end

   // ---- item latched at the input transfer
   logic                 req_xfer;
   logic [OP_W-1:0]      op_ff;
   logic [CUST_IN_W-1:0] cust_ff;
   logic [AMT_W-1:0]     amt_ff [LANE_FIELDS];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff     <= req_op;
         cust_ff   <= req_customer;
         amt_ff[0] <= req_amount_0;
         amt_ff[1] <= req_amount_1;
         amt_ff[2] <= req_amount_2;
         amt_ff[3] <= req_amount_3;
      end
   end

   // customers beyond the configured count are ignored
   logic              cust_ok;
   logic [CUST_W-1:0] cust_idx;

   assign cust_ok  = (int'(cust_ff) < CUSTOMERS);
   assign cust_idx = CUST_W'(cust_ff);

   // ---- safety scan bookkeeping
   logic [CUST_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]     idle_cnt_ff, idle_cnt_in;
   logic [CNT_W-1:0]     done_cnt_ff, done_cnt_in;
   logic [CUSTOMERS-1:0] done_ff, done_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic all_done, stuck, scan_step;

   assign all_done  = (done_cnt_ff == CNT_W'(CUSTOMERS));
   assign stuck     = (idle_cnt_ff == CNT_W'(CUSTOMERS));
   assign scan_step = (state_ff == ST_SCAN) && !all_done && !stuck;

   // ---- resource lanes and merge
   lane_ctrl_type         lane_ctrl;
   lane_flag_type         lane_flags [RESOURCES];
   logic [TOT_W-1:0]      lane_avail [RESOURCES];
   logic [COUNT_BITS-1:0] lane_amt   [RESOURCES];
   logic [TOT_W-1:0]      lane_total [RESOURCES];
   logic [CUST_W-1:0]     rd_addr;

   logic [STATUS_W-1:0] chk_status;
   logic                req_ok, fits_all;

   assign rd_addr = (state_ff == ST_SCAN) ? scan_idx_ff : cust_idx;

   for (genvar r = 0; r < RESOURCES; r++) begin : g_lane
      if (r < LANE_FIELDS) begin : g_field
         // amounts wider than a count saturate
         assign lane_amt[r]   = (int'(amt_ff[r]) > CNT_MAX) ? COUNT_BITS'(CNT_MAX)
                                                            : COUNT_BITS'(amt_ff[r]);
         assign lane_total[r] = total_ff[r];
      end else begin : g_blank
         assign lane_amt[r]   = '0;
         assign lane_total[r] = '0;
      end

      bsa_lane #(
         .CUSTOMERS  (CUSTOMERS),
         .COUNT_BITS (COUNT_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .total    (lane_total[r]),
         .amount   (lane_amt[r]),
         .cust_idx (cust_idx),
         .rd_addr  (rd_addr),
         .flags    (lane_flags[r]),
         .avail    (lane_avail[r])
      );
   end

   bsa_merge #(
      .RESOURCES (RESOURCES)
   ) u_merge (
      .flags    (lane_flags),
      .op       (op_ff),
      .cust_ok  (cust_ok),
      .status   (chk_status),
      .req_ok   (req_ok),
      .fits_all (fits_all)
   );

   always_comb begin
      lane_ctrl.load     = (state_ff == ST_CHECK);
      lane_ctrl.scan     = (state_ff == ST_SCAN);
      lane_ctrl.take     = scan_step && !done_ff[scan_idx_ff] && fits_all;
      lane_ctrl.claim_we = (state_ff == ST_CHECK) && cust_ok && (op_ff == OP_CLAIM)
                           && (chk_status == STS_OK);
      lane_ctrl.rel_we   = (state_ff == ST_CHECK) && cust_ok && (op_ff == OP_RELEASE)
                           && (chk_status == STS_OK);
      lane_ctrl.commit   = (state_ff == ST_SCAN) && all_done;
   end

   // ---- output register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [TOT_W-1:0]    rsp_avail_ff [LANE_FIELDS];
   logic [TOT_W-1:0]    avail_field  [LANE_FIELDS];
   logic                out_free, rsp_load;

   for (genvar f = 0; f < LANE_FIELDS; f++) begin : g_field_out
      if (f < RESOURCES) begin : g_used
         assign avail_field[f] = lane_avail[f];
      end else begin : g_zero
         assign avail_field[f] = '0;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_FINISH) && out_free;

   // ---- sequencer
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      idle_cnt_in = idle_cnt_ff;
      done_cnt_in = done_cnt_ff;
      done_in     = done_ff;
      status_in   = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            status_in   = chk_status;
            scan_idx_in = '0;
            idle_cnt_in = '0;
            done_cnt_in = '0;
            done_in     = '0;
            state_in    = req_ok ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (all_done) begin
               state_in = ST_FINISH;
            end else if (stuck) begin
               status_in = STS_UNSAFE;
               state_in  = ST_FINISH;
            end else begin
               // a full round with no customer finishing means unsafe
               if (lane_ctrl.take) begin
                  done_in[scan_idx_ff] = 1'b1;
                  done_cnt_in          = done_cnt_ff + CNT_W'(1);
                  idle_cnt_in          = '0;
               end else begin
                  idle_cnt_in = idle_cnt_ff + CNT_W'(1);
               end
               scan_idx_in = (scan_idx_ff == CUST_W'(CUSTOMERS - 1)) ? '0
                                                                      : scan_idx_ff + CUST_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      idle_cnt_ff <= idle_cnt_in;
      done_cnt_ff <= done_cnt_in;
      done_ff     <= done_in;
      status_ff   <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         for (int f = 0; f < LANE_FIELDS; f++) rsp_avail_ff[f] <= avail_field[f];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_avail_0 = rsp_avail_ff[0];
   assign rsp_avail_1 = rsp_avail_ff[1];
   assign rsp_avail_2 = rsp_avail_ff[2];
   assign rsp_avail_3 = rsp_avail_ff[3];

   // ---- checks
   `BSA_ASSERT_NEXT(a_xfer_to_check, clock, reset, req_xfer, state_ff == ST_CHECK, "transfer did not start a check")
   `BSA_ASSERT_IMPL(a_done_count, clock, reset, state_ff == ST_SCAN, int'(done_cnt_ff) == $countones(done_ff), "done count out of step with done bits")
   `BSA_ASSERT_IMPL(a_idle_bound, clock, reset, state_ff == ST_SCAN, idle_cnt_ff <= CNT_W'(CUSTOMERS), "scan ran past a full idle round")
   `BSA_ASSERT_NEXT(a_finish_out, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE), "finished item not presented")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Banker's safe allocator testbench
// Drives claim, request and release transfers into the allocator and checks
// every result (status and available vector) against a built-in prediction
// of the claim and allocation tables, including the safety scan. Directed
// cases cover each status code, then random phases run mostly well-formed
// workloads over several resource totals, with random sender gaps and receiver
// stalls; one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import bsa_pkg::*;

   localparam int          CUSTOMERS    = 8;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int          DRAIN_CYCLES = 120;   // settle time after the final drain
   localparam int          MAX_REPORTS  = 10;

   // op code the block must ignore
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // csr register map: one total per resource lane
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_RES0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_RES1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_RES2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_RES3 = 2'd3;

   typedef logic [LANE_FIELDS-1:0][AMT_W-1:0] lane_vec_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      lane_vec_type        avail;
   } alloc_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BLOCKS
   } stall_mode_type;

   // ------------------------------------------------------------------------
   // Clock, reset and DUT ports (every input known from time zero)
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op       = '0;
   logic [CUST_IN_W-1:0] req_customer = '0;
   logic [AMT_W-1:0]     req_amount_0 = '0;
   logic [AMT_W-1:0]     req_amount_1 = '0;
   logic [AMT_W-1:0]     req_amount_2 = '0;
   logic [AMT_W-1:0]     req_amount_3 = '0;

   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b1;
   logic [STATUS_W-1:0]  rsp_status;
   logic [TOT_W-1:0]     rsp_avail_0;
   logic [TOT_W-1:0]     rsp_avail_1;
   logic [TOT_W-1:0]     rsp_avail_2;
   logic [TOT_W-1:0]     rsp_avail_3;

   logic                 csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [TOT_W-1:0]     csr_wdata    = '0;

   always #2 clock = ~clock;

   bankers_safe_allocator #(
      .CUSTOMERS  (CUSTOMERS),
      .RESOURCES  (LANE_FIELDS),
      .COUNT_BITS (AMT_W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_customer (req_customer),
      .req_amount_0 (req_amount_0),
      .req_amount_1 (req_amount_1),
      .req_amount_2 (req_amount_2),
      .req_amount_3 (req_amount_3),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_avail_0  (rsp_avail_0),
      .rsp_avail_1  (rsp_avail_1),
      .rsp_avail_2  (rsp_avail_2),
      .rsp_avail_3  (rsp_avail_3),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Shadow of the allocator state
   // ------------------------------------------------------------------------
   logic [TOT_W-1:0] total_tab [LANE_FIELDS];
   logic [AMT_W-1:0] claim_tab [CUSTOMERS][LANE_FIELDS];
   logic [AMT_W-1:0] held_tab  [CUSTOMERS][LANE_FIELDS];

   alloc_result_type pending_results[$];

   int          error_count  = 0;
   int          items_sent   = 0;
   int          results_seen = 0;
   int          status_seen [8];
   int unsigned cycle_count  = 0;

   // sender pacing
   bit gaps_on    = 1'b1;
   int burst_left = 0;

   // receiver pattern and hold-off request
   bit             hold_pending = 1'b0;
   int             hold_left    = 0;
   int             pattern_left = 0;
   stall_mode_type stall_mode   = STALL_NONE;

   // claim minus allocation, floored at zero
   function automatic int need_of(input int c, input int l);
      return (claim_tab[c][l] > held_tab[c][l]) ? claim_tab[c][l] - held_tab[c][l] : 0;
   endfunction

   // total minus summed allocations, saturating at zero when a total shrank
   function automatic lane_vec_type free_units();
      lane_vec_type units;
      int           used;
      for (int l = 0; l < LANE_FIELDS; l++) begin
         used = 0;
         for (int c = 0; c < CUSTOMERS; c++)
            used += held_tab[c][l];
         units[l] = AMT_W'((total_tab[l] > used) ? total_tab[l] - used : 0);
      end
      return units;
   endfunction

   // Apply one accepted transfer to the shadow tables, return its result.
   function automatic alloc_result_type apply_item(input logic [OP_W-1:0] op,
                                                   input logic [CUST_IN_W-1:0] cust,
                                                   input lane_vec_type amt);
      alloc_result_type res;
      lane_vec_type     avail;
      int               work [LANE_FIELDS];
      bit               finished [CUSTOMERS];
      bit               progress;
      bit               fits;
      res.status = STS_OK;
      avail = free_units();
      case (op)
         OP_CLAIM: begin
            for (int l = 0; l < LANE_FIELDS; l++)
               if (amt[l] < held_tab[cust][l]) res.status = STS_CLAIM_LOW;
            if (res.status == STS_OK)
               for (int l = 0; l < LANE_FIELDS; l++) claim_tab[cust][l] = amt[l];
         end
         OP_REQUEST: begin
            // need first, then availability, then the safety scan
            for (int l = 0; l < LANE_FIELDS; l++)
               if (amt[l] > need_of(cust, l)) res.status = STS_OVER_NEED;
            if (res.status == STS_OK)
               for (int l = 0; l < LANE_FIELDS; l++)
                  if (amt[l] > avail[l]) res.status = STS_OVER_AVAIL;
            if (res.status == STS_OK) begin
               for (int l = 0; l < LANE_FIELDS; l++) begin
                  held_tab[cust][l] += amt[l];
                  work[l] = avail[l] - amt[l];
               end
               for (int c = 0; c < CUSTOMERS; c++) finished[c] = 1'b0;
               progress = 1'b1;
               while (progress) begin
                  progress = 1'b0;
                  for (int c = 0; c < CUSTOMERS; c++) begin
                     if (!finished[c]) begin
                        fits = 1'b1;
                        for (int l = 0; l < LANE_FIELDS; l++)
                           if (need_of(c, l) > work[l]) fits = 1'b0;
                        if (fits) begin
                           for (int l = 0; l < LANE_FIELDS; l++) work[l] += held_tab[c][l];
                           finished[c] = 1'b1;
                           progress = 1'b1;
                        end
                     end
                  end
               end
               for (int c = 0; c < CUSTOMERS; c++)
                  if (!finished[c]) res.status = STS_UNSAFE;
               if (res.status == STS_UNSAFE)
                  for (int l = 0; l < LANE_FIELDS; l++) held_tab[cust][l] -= amt[l];
            end
         end
         OP_RELEASE: begin
            for (int l = 0; l < LANE_FIELDS; l++)
               if (amt[l] > held_tab[cust][l]) res.status = STS_OVER_RELEASE;
            if (res.status == STS_OK)
               for (int l = 0; l < LANE_FIELDS; l++) held_tab[cust][l] -= amt[l];
         end
         default: ;  // unused op: state untouched
      endcase
      res.avail = free_units();
      return res;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t ns: ERROR %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // Request channel: one transfer per call. Valid is left high on return so
   // back-to-back transfers never lower and raise it in the same step; gaps
   // (and the drain wait) are the only places that lower it.
   // ------------------------------------------------------------------------
   task automatic send_item(input logic [OP_W-1:0] op, input logic [CUST_IN_W-1:0] cust,
                            input lane_vec_type amt);
      int gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid    <= 1'b1;
      req_op       <= op;
      req_customer <= cust;
      req_amount_0 <= amt[0];
      req_amount_1 <= amt[1];
      req_amount_2 <= amt[2];
      req_amount_3 <= amt[3];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer taken at this edge
      pending_results.push_back(apply_item(op, cust, amt));
      items_sent++;
   endtask

   // Drop valid and wait until every predicted result has been seen.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [TOT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      total_tab[idx] = value;
   endtask

   // Totals change only with the block idle.
   task automatic write_totals(input lane_vec_type totals);
      wait_drained();
      csr_write(CSR_TOTAL_RES0, totals[0]);
      csr_write(CSR_TOTAL_RES1, totals[1]);
      csr_write(CSR_TOTAL_RES2, totals[2]);
      csr_write(CSR_TOTAL_RES3, totals[3]);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed traffic shaped from the shadow tables, with a share
   // of deliberate violations and plain noise.
   task automatic send_workload_item();
      logic [OP_W-1:0]      op;
      logic [CUST_IN_W-1:0] cust;
      lane_vec_type         amt;
      lane_vec_type         avail;
      int                   pick;
      int                   room;
      int                   held;
      int                   lane;
      cust  = CUST_IN_W'($urandom_range(0, CUSTOMERS - 1));
      avail = free_units();
      pick  = $urandom_range(0, 99);
      lane  = $urandom_range(0, LANE_FIELDS - 1);
      if (pick < 8) begin
         op  = OP_W'($urandom_range(0, 3));   // includes the unused code
         amt = $urandom;
      end else if (pick < 24) begin
         op = OP_CLAIM;
         for (int l = 0; l < LANE_FIELDS; l++) begin
            held = held_tab[cust][l];
            room = (total_tab[l] > held) ? total_tab[l] - held : 0;
            amt[l] = AMT_W'(held + $urandom_range(0, room));
         end
         if ($urandom_range(0, 9) == 0 && held_tab[cust][lane] != 0)
            amt[lane] = held_tab[cust][lane] - 8'd1;   // claim below allocation
      end else if (pick < 70) begin
         op = OP_REQUEST;
         for (int l = 0; l < LANE_FIELDS; l++) begin
            room = need_of(cust, l);
            if (avail[l] < room) room = avail[l];
            amt[l] = AMT_W'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, room));
         end
         case ($urandom_range(0, 11))
            0: if (need_of(cust, lane) < 255) amt[lane] = AMT_W'(need_of(cust, lane) + 1);
            1: if (avail[lane] < 255) amt[lane] = avail[lane] + 8'd1;
            default: ;
         endcase
      end else begin
         op = OP_RELEASE;
         for (int l = 0; l < LANE_FIELDS; l++)
            amt[l] = AMT_W'($urandom_range(0, held_tab[cust][l]));
         if ($urandom_range(0, 3) == 0)
            for (int l = 0; l < LANE_FIELDS; l++) amt[l] = held_tab[cust][l];
         if ($urandom_range(0, 11) == 0 && held_tab[cust][lane] < 255)
            amt[lane] = held_tab[cust][lane] + 8'd1;   // over-release
      end
      send_item(op, cust, amt);
   endtask

   // ------------------------------------------------------------------------
   // Result channel: stall pattern with its own long hold-off counter
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_pacing
      bit stall_now;
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left--;
      end
      if (pattern_left == 0) begin
         stall_mode   = stall_mode_type'($urandom_range(0, 3));
         pattern_left = $urandom_range(20, 300);
      end else begin
         pattern_left--;
      end
      case (stall_mode)
         STALL_NONE:  stall_now = 1'b0;
         STALL_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
         STALL_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
         default:     stall_now = pattern_left[2];   // stall in blocks of four
      endcase
      rsp_stall <= (hold_left != 0) || stall_now;
   end

   // Each result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      alloc_result_type want;
      lane_vec_type     got;
      bit               mismatch;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_avail_3, rsp_avail_2, rsp_avail_1, rsp_avail_0};
         results_seen++;
         status_seen[rsp_status]++;
         if (pending_results.size() == 0) begin
            flag_error($sformatf("result with none pending: status %0d avail %0d/%0d/%0d/%0d",
                                 rsp_status, got[0], got[1], got[2], got[3]));
         end else begin
            want = pending_results.pop_front();
            mismatch = (want.status !== rsp_status);
            for (int l = 0; l < LANE_FIELDS; l++)
               if (want.avail[l] !== got[l]) mismatch = 1'b1;
            if (mismatch)
               flag_error($sformatf({"result %0d: exp status %0d avail %0d/%0d/%0d/%0d,",
                                     " got status %0d avail %0d/%0d/%0d/%0d"},
                                    results_seen, want.status, want.avail[0], want.avail[1],
                                    want.avail[2], want.avail[3], rsp_status,
                                    got[0], got[1], got[2], got[3]));
         end
      end
   end

   // Watchdog: ends a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Totals are zero out of reset; a zero release and an unused op just
   // report the empty available vector.
   task automatic test_idle_after_reset();
      send_item(OP_RELEASE, 3'd7, '0);
      send_item(OP_UNUSED, 3'd0, {4{8'd255}});
   endtask

   // One case per status code, plus the zero request and claim above total.
   task automatic test_directed_ops();
      write_totals({4{8'd10}});
      send_item(OP_CLAIM,   3'd0, {4{8'd8}});
      send_item(OP_CLAIM,   3'd1, {4{8'd8}});
      send_item(OP_REQUEST, 3'd0, {4{8'd5}});              // granted
      send_item(OP_REQUEST, 3'd1, {4{8'd5}});              // leaves nobody able to finish
      send_item(OP_REQUEST, 3'd1, {4{8'd6}});              // within need, over available
      send_item(OP_REQUEST, 3'd0, {8'd0, 8'd0, 8'd0, 8'd4}); // over need on one lane
      send_item(OP_REQUEST, 3'd1, '0);                     // zero request, still safe
      send_item(OP_CLAIM,   3'd1, {4{8'd255}});            // claim above the total is allowed
      send_item(OP_REQUEST, 3'd1, '0);                     // zero request, now unsafe
      send_item(OP_RELEASE, 3'd0, {8'd0, 8'd0, 8'd0, 8'd6}); // more than held
      send_item(OP_CLAIM,   3'd0, '0);                     // claim below allocation
      send_item(OP_RELEASE, 3'd0, {4{8'd5}});
      send_item(OP_CLAIM,   3'd1, '0);
      send_item(OP_RELEASE, 3'd7, {4{8'd255}});
      send_item(OP_UNUSED,  3'd3, {4{8'hAA}});
      send_item(OP_UNUSED,  3'd5, {4{8'h55}});
   endtask

   // Lower totals under live allocations: available saturates at zero.
   task automatic test_total_shrink();
      send_item(OP_CLAIM,   3'd2, {4{8'd6}});
      send_item(OP_REQUEST, 3'd2, {4{8'd6}});
      write_totals({8'd255, 8'd0, 8'd3, 8'd10});
      send_item(OP_REQUEST, 3'd2, '0);
      send_item(OP_RELEASE, 3'd2, {4{8'd6}});
      send_item(OP_REQUEST, 3'd2, {4{8'd1}});
   endtask

   // Receiver holds off while the sender keeps offering back to back, so the
   // block backs up and stalls its input.
   task automatic test_input_pressure();
      write_totals({4{8'd200}});
      gaps_on      = 1'b0;
      hold_pending = 1'b1;
      repeat (24) send_workload_item();
      gaps_on      = 1'b1;
   endtask

   // Random workload phases over max, zero, small, random and mixed totals.
   task automatic test_random_workload();
      lane_vec_type totals;
      lane_vec_type give_back;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       totals = {4{8'd255}};
            1:       totals = '0;
            2, 5:    for (int l = 0; l < LANE_FIELDS; l++)
                        totals[l] = AMT_W'($urandom_range(1, 15));
            3:       totals = $urandom;
            default: totals = {8'd1, 8'd128, 8'd0, 8'd255};
         endcase
         // hand back current allocations so each phase starts mostly free
         for (int c = 0; c < CUSTOMERS; c++) begin
            for (int l = 0; l < LANE_FIELDS; l++) give_back[l] = held_tab[c][l];
            if (give_back != '0) send_item(OP_RELEASE, CUST_IN_W'(c), give_back);
         end
         write_totals(totals);
         repeat ((p == 1) ? 150 : 330) send_workload_item();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      for (int l = 0; l < LANE_FIELDS; l++) begin
         total_tab[l] = '0;
         for (int c = 0; c < CUSTOMERS; c++) begin
            claim_tab[c][l] = '0;
            held_tab[c][l]  = '0;
         end
      end
      for (int s = 0; s < 8; s++) status_seen[s] = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_after_reset();
      test_directed_ops();
      test_total_shrink();
      test_input_pressure();
      test_random_workload();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d predicted results never arrived", pending_results.size()));

      $display("Covered %0d transfers in, %0d results out over %0d cycles, %0d mismatches",
               items_sent, results_seen, cycle_count, error_count);
      $display("Statuses: ok %0d, over-need %0d, over-avail %0d, unsafe %0d, over-release %0d, claim-low %0d",
               status_seen[STS_OK], status_seen[STS_OVER_NEED], status_seen[STS_OVER_AVAIL],
               status_seen[STS_UNSAFE], status_seen[STS_OVER_RELEASE], status_seen[STS_CLAIM_LOW]);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
